/* hw/rtl/atbs_pkg.sv */
// Package for the alias table builder and sampler: constants, codes, types.
// No dependencies; used by the divider, datapath, controller and top level.
`timescale 1ns / 1ps
package atbs_pkg;
  localparam int MaxEntries = 64;
  localparam int IdxBits = 6;
  localparam int CntBits = 7;
  localparam int WeightBits = 16;
  localparam int FracBits = 16;
  localparam int SumBits = 22;
  localparam int ScBits = 23;
  localparam int ThBits = 17;
  localparam int ProdBits = 45;
  localparam int QuoBits = ProdBits - SumBits;

  typedef logic [2:0] status_t;
  localparam status_t StOk = 3'd0;
  localparam status_t StBuilt = 3'd1;
  localparam status_t StNotBuilt = 3'd2;
  localparam status_t StZeroSum = 3'd3;
  localparam status_t StBadCol = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_START, S_DIV_WAIT, S_PAIR_RD, S_PAIR_WAIT, S_PAIR_UPD,
    S_FLUSH_RD, S_FLUSH_WR
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_set;
    logic scale_init;
    logic div_start;
    logic div_store;
    logic pair_rd;
    logic pair_upd;
    logic flush_rd;
    logic flush_wr;
    logic sample_rd;
    logic emit_status;
    status_t status;
    logic set_built;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic scale_last;
    logic stacks_pairable;
    logic stacks_empty;
    logic built;
    logic sum_zero;
    logic col_bad;
  } stat_t;
endpackage

/* hw/rtl/atbs_ram.sv */
// Generic single-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module atbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/atbs_div.sv */
// Radix-2 restoring divider for weight scaling, one quotient bit per cycle.
// Depends on atbs_pkg.
`timescale 1ns / 1ps
module atbs_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [atbs_pkg::ProdBits-1:0] dividend,
  input  logic [atbs_pkg::SumBits-1:0] divisor,
  output logic done,
  output logic [atbs_pkg::ScBits-1:0] quotient
);
  import atbs_pkg::*;
  logic [ProdBits-1:0] q_r, q_nxt;
  logic [SumBits:0] rem_r, rem_nxt;
  logic [SumBits-1:0] dvs_r;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [SumBits+1:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r, q_r[ProdBits-1]} - {2'b0, dvs_r};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'(ProdBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[SumBits+1]) rem_nxt = trial[SumBits:0];
      else rem_nxt = {rem_r[SumBits-1:0], q_r[ProdBits-1]};
      q_nxt = {q_r[ProdBits-2:0], ~trial[SumBits+1]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done = !busy_r && !start;
  assign quotient = q_r[ScBits-1:0];
endmodule

/* hw/rtl/atbs_datapath.sv */
// Datapath: weight store, scaling, stacks, threshold and alias tables.
// Depends on atbs_pkg, atbs_ram, atbs_div.
`timescale 1ns / 1ps
module atbs_datapath (
  input  logic clk,
  input  logic rst_n,
  input  atbs_pkg::ctrl_t ctrl,
  output atbs_pkg::stat_t stat,
  input  logic [atbs_pkg::WeightBits-1:0] in_weight,
  input  logic [atbs_pkg::IdxBits-1:0] in_rand_column,
  input  logic [15:0] in_rand_fraction,
  output logic [2:0] out_status,
  output logic [atbs_pkg::IdxBits-1:0] out_sample,
  output logic out_valid
);
  import atbs_pkg::*;
  localparam logic [ScBits-1:0] One = ScBits'(1) << FracBits;

  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic [SumBits-1:0] sum_r, sum_nxt;
  logic built_r;
  logic [CntBits-1:0] sidx_r, stop_r, ltop_r;
  logic [IdxBits-1:0] g_r, l_r, col_r;
  logic [ThBits-1:0] fr_r;
  logic [2:0] st_r;
  logic [IdxBits-1:0] smp_r;
  logic v_r;
  logic flush_large_r;

  // weight store
  logic [WeightBits-1:0] w_rd;
  logic [CntBits-1:0] load_base;
  assign load_base = ctrl.clear_set ? '0 : cnt_r;
  atbs_ram #(.Width(WeightBits), .Depth(MaxEntries)) u_w (
    .clk, .we(ctrl.load && load_base < CntBits'(MaxEntries)),
    .waddr(load_base[IdxBits-1:0]), .wdata(in_weight),
    .raddr(ctrl.scale_init ? '0 : sidx_r[IdxBits-1:0] + IdxBits'(1)),
    .rdata(w_rd));

  // divider: w * n * ONE / sum
  logic [ProdBits-1:0] prod;
  logic [ScBits-1:0] quo;
  logic div_done;
  assign prod = (ProdBits'(w_rd) * ProdBits'(cnt_r)) << FracBits;
  atbs_div u_div (.clk, .rst_n, .start(ctrl.div_start), .dividend(prod),
    .divisor(sum_r), .done(div_done), .quotient(quo));

  // scaled work, stacks, tables
  logic sc_we; logic [IdxBits-1:0] sc_wa, sc_ra; logic [ScBits-1:0] sc_wd, sc_rd, sc_rd2;
  logic ss_we, ls_we; logic [IdxBits-1:0] ss_wa, ls_wa, ss_wd, ls_wd, ss_rd, ls_rd;
  logic t_we; logic [IdxBits-1:0] t_wa, t_ra; logic [ThBits-1:0] t_wd, t_rd;
  logic [IdxBits-1:0] a_wd, a_rd;
  logic [ScBits-1:0] gnew;
  logic gbig;

  atbs_ram #(.Width(ScBits), .Depth(MaxEntries)) u_sc (.clk, .we(sc_we),
    .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd));
  atbs_ram #(.Width(ScBits), .Depth(MaxEntries)) u_sc2 (.clk, .we(sc_we),
    .waddr(sc_wa), .wdata(sc_wd), .raddr(ls_rd), .rdata(sc_rd2));
  atbs_ram #(.Width(IdxBits), .Depth(MaxEntries)) u_ss (.clk, .we(ss_we),
    .waddr(ss_wa), .wdata(ss_wd), .raddr(IdxBits'(stop_r - 7'd1)), .rdata(ss_rd));
  atbs_ram #(.Width(IdxBits), .Depth(MaxEntries)) u_ls (.clk, .we(ls_we),
    .waddr(ls_wa), .wdata(ls_wd), .raddr(IdxBits'(ltop_r - 7'd1)), .rdata(ls_rd));
  atbs_ram #(.Width(ThBits), .Depth(MaxEntries)) u_th (.clk, .we(t_we),
    .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  atbs_ram #(.Width(IdxBits), .Depth(MaxEntries)) u_al (.clk, .we(t_we),
    .waddr(t_wa), .wdata(a_wd), .raddr(t_ra), .rdata(a_rd));

  // pair flow: PAIR_RD lets the stack top reads settle; PAIR_WAIT registers
  // g/l and reads scaled[l] and scaled[g] straight from the tops; PAIR_UPD writes.
  assign gnew = sc_rd2 + sc_rd - One;
  assign gbig = gnew >= One;
  assign sc_ra = ss_rd;
  assign t_ra = in_rand_column;

  always_comb begin
    sc_we = 1'b0; sc_wa = sidx_r[IdxBits-1:0]; sc_wd = quo;
    ss_we = 1'b0; ss_wa = stop_r[IdxBits-1:0]; ss_wd = sidx_r[IdxBits-1:0];
    ls_we = 1'b0; ls_wa = ltop_r[IdxBits-1:0]; ls_wd = sidx_r[IdxBits-1:0];
    t_we = 1'b0; t_wa = l_r; t_wd = ThBits'(sc_rd); a_wd = g_r;
    if (ctrl.div_store) begin
      sc_we = 1'b1;
      if (quo >= One) ls_we = 1'b1; else ss_we = 1'b1;
    end
    if (ctrl.pair_upd) begin
      t_we = 1'b1;
      sc_we = 1'b1; sc_wa = g_r; sc_wd = gnew;
      if (gbig) begin ls_we = 1'b1; ls_wa = IdxBits'(ltop_r - 7'd1); ls_wd = g_r; end
      else begin ss_we = 1'b1; ss_wa = IdxBits'(stop_r - 7'd1); ss_wd = g_r; end
    end
    if (ctrl.flush_wr) begin
      t_we = 1'b1;
      t_wa = flush_large_r ? g_r : l_r;
      t_wd = ThBits'(One);
      a_wd = t_wa;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r; sum_nxt = sum_r;
    if (ctrl.load) begin
      if (ctrl.clear_set) begin cnt_nxt = '0; sum_nxt = '0; end
      if (cnt_nxt < CntBits'(MaxEntries)) begin
        sum_nxt = sum_nxt + SumBits'(in_weight);
        cnt_nxt = cnt_nxt + 7'd1;
      end
    end
    if (ctrl.emit_status && ctrl.status == StZeroSum) begin
      cnt_nxt = '0; sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; sum_r <= '0; built_r <= 1'b0; v_r <= 1'b0;
      stop_r <= '0; ltop_r <= '0; sidx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt; sum_r <= sum_nxt;
      if (ctrl.load) built_r <= 1'b0;
      if (ctrl.set_built) built_r <= 1'b1;
      v_r <= ctrl.emit_status;
      if (ctrl.scale_init) begin sidx_r <= '0; stop_r <= '0; ltop_r <= '0; end
      if (ctrl.div_store) begin
        sidx_r <= sidx_r + 7'd1;
        if (quo >= One) ltop_r <= ltop_r + 7'd1; else stop_r <= stop_r + 7'd1;
      end
      if (ctrl.pair_rd) begin g_r <= ls_rd; l_r <= ss_rd; end
      if (ctrl.pair_upd) begin
        if (!gbig) ltop_r <= ltop_r - 7'd1;
        else stop_r <= stop_r - 7'd1;
      end
      if (ctrl.flush_rd) begin
        flush_large_r <= ltop_r != '0;
        if (ltop_r != '0) begin g_r <= ls_rd; ltop_r <= ltop_r - 7'd1; end
        else begin l_r <= ss_rd; stop_r <= stop_r - 7'd1; end
      end
    end
    if (ctrl.sample_rd) begin col_r <= in_rand_column; fr_r <= ThBits'(in_rand_fraction); end
    st_r <= ctrl.status;
    smp_r <= (fr_r < t_rd) ? col_r : a_rd;
  end

  assign stat.div_done = div_done;
  assign stat.scale_last = sidx_r + 7'd1 >= cnt_r;
  assign stat.stacks_pairable = stop_r != '0 && ltop_r != '0;
  assign stat.stacks_empty = stop_r == '0 && ltop_r == '0;
  assign stat.built = built_r;
  assign stat.sum_zero = sum_r == '0;
  assign stat.col_bad = CntBits'(in_rand_column) >= cnt_r;
  assign out_status = st_r;
  assign out_sample = smp_r;
  assign out_valid = v_r;
endmodule

/* hw/rtl/atbs_ctrl.sv */
// Controller: sequences load, build passes and sampling.
// Depends on atbs_pkg.
`timescale 1ns / 1ps
module atbs_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic in_cmd,
  input  logic in_last,
  input  atbs_pkg::stat_t stat,
  output atbs_pkg::ctrl_t ctrl,
  output logic busy
);
  import atbs_pkg::*;
  state_t state_r, state_nxt;
  logic acc;
  assign acc = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc) begin
        if (in_cmd) state_nxt = S_IDLE;
        else if (in_last) state_nxt = S_DIV_START;
      end
      S_DIV_START: state_nxt = stat.sum_zero ? S_IDLE : S_DIV_WAIT;
      S_DIV_WAIT: if (stat.div_done)
        state_nxt = stat.scale_last ? S_PAIR_RD : S_DIV_START;
      S_PAIR_RD: state_nxt = stat.stacks_pairable ? S_PAIR_WAIT :
        (stat.stacks_empty ? S_IDLE : S_FLUSH_RD);
      S_PAIR_WAIT: state_nxt = S_PAIR_UPD;
      S_PAIR_UPD: state_nxt = S_PAIR_RD;
      S_FLUSH_RD: state_nxt = S_FLUSH_WR;
      S_FLUSH_WR: state_nxt = stat.stacks_empty ? S_IDLE : S_FLUSH_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctrl = '0;
    busy = state_r != S_IDLE;
    unique case (state_r)
      S_IDLE: if (acc) begin
        if (!in_cmd) begin
          ctrl.load = 1'b1;
          ctrl.clear_set = stat.built;
          ctrl.scale_init = in_last;
        end else begin
          ctrl.sample_rd = 1'b1;
        end
      end
      S_DIV_START: begin
        if (stat.sum_zero) begin
          ctrl.emit_status = 1'b1; ctrl.status = StZeroSum;
        end else ctrl.div_start = 1'b1;
      end
      S_DIV_WAIT: ctrl.div_store = stat.div_done;
      S_PAIR_RD: begin
        if (stat.stacks_empty) begin
          ctrl.emit_status = 1'b1; ctrl.status = StBuilt; ctrl.set_built = 1'b1;
        end
      end
      S_PAIR_WAIT: ctrl.pair_rd = 1'b1;
      S_PAIR_UPD: ctrl.pair_upd = 1'b1;
      S_FLUSH_RD: ctrl.flush_rd = 1'b1;
      S_FLUSH_WR: begin
        ctrl.flush_wr = 1'b1;
        if (stat.stacks_empty) begin
          ctrl.emit_status = 1'b1; ctrl.status = StBuilt; ctrl.set_built = 1'b1;
        end
      end
      default: ctrl = '0;
    endcase
  end
endmodule

/* hw/rtl/alias_table_builder_sampler_top.sv */
// Top level of the alias table builder and sampler.
// Depends on atbs_pkg, atbs_ctrl, atbs_datapath.
`timescale 1ns / 1ps
// A load is taken on acceptance. A draw raises busy through smp_busy_r and its
// result strobes from pend_r, or from fin_v_r on an error status. The load
// marked last runs the build while busy is high: a zero sum strobes its status
// from the divider start state; otherwise each entry passes a start state and a
// wait on the radix-2 divider, each pairing the read, wait and update states,
// the stacks are checked after the last pairing, each leftover entry is read
// and written, and the status strobes in the cycle after the last write or
// check. The result strobe out_valid lasts one cycle and cannot be stalled.
module alias_table_builder_sampler_top (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic in_cmd,
  input  logic [15:0] in_weight,
  input  logic in_last,
  input  logic [5:0] in_rand_column,
  input  logic [15:0] in_rand_fraction,
  output logic out_valid,
  output logic [2:0] out_status,
  output logic [5:0] out_sample
);
  import atbs_pkg::*;
  ctrl_t ctrl;
  stat_t stat;
  logic ctrl_busy, smp_busy_r;
  logic [2:0] smp_st_r;
  logic [2:0] dp_status;
  logic [5:0] dp_sample;
  logic dp_valid;
  logic sacc;
  logic pend_r;
  assign sacc = start && !busy && in_cmd;
  assign busy = ctrl_busy || smp_busy_r;

  atbs_ctrl u_ctrl (.clk, .rst_n, .start(start && !smp_busy_r), .in_cmd, .in_last,
    .stat, .ctrl, .busy(ctrl_busy));
  atbs_datapath u_dp (.clk, .rst_n, .ctrl, .stat, .in_weight, .in_rand_column,
    .in_rand_fraction, .out_status(dp_status), .out_sample(dp_sample),
    .out_valid(dp_valid));

  // sample path: table read completes next cycle; sample formed the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_busy_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      smp_busy_r <= sacc;
      pend_r <= smp_busy_r && smp_st_r == StOk;
    end
    if (sacc) smp_st_r <= !stat.built ? StNotBuilt : (stat.col_bad ? StBadCol : StOk);
  end

  logic [2:0] fin_st_r;
  logic fin_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) fin_v_r <= 1'b0;
    else fin_v_r <= smp_busy_r && smp_st_r != StOk;
    fin_st_r <= smp_st_r;
  end

  // status from controller when sample path idle
  logic [IdxBits-1:0] pick;
  assign pick = dp_sample;
  always_comb begin
    out_valid = dp_valid || fin_v_r || pend_r;
    out_status = dp_valid ? dp_status : (fin_v_r ? fin_st_r : StOk);
    out_sample = pend_r ? pick : '0;
  end
endmodule
